// ----- rtl/dbsad_pkg.sv -----
// Shared types, widths and pattern codes for the decimated block SAD.
// Used by every module of the block; depends on nothing.
package dbsad_pkg;

   localparam int PIXEL_W    = 8;
   localparam int WORD_W     = 64;
   localparam int WORD_PIX   = WORD_W / PIXEL_W;
   localparam int MAX_LANES  = 16;
   localparam int BEST_W     = 17;
   localparam int SUM_W      = 17;
   localparam int SAD_W      = 16;
   localparam int ROW_SUM_W  = 12;
   localparam int MODE_W     = 3;
   localparam int BIAS_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int COL_W      = 4;

   localparam logic [MODE_W-1:0] MODE_ALL      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHECKER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EVEN_ALT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUARTER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EIGHTH   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_BIAS    = 1'd1;

   typedef logic [MAX_LANES-1:0][PIXEL_W-1:0] lane_bus_type;

   // Per-row control that travels alongside the lane data.
   typedef struct packed {
      logic              first;
      logic              last;
      logic              full;
      logic [BEST_W-1:0] best;
   } row_ctl_type;

   // Is column col used on a row whose low index bits are row_lo?
   // Unknown codes behave as full sampling.
   function automatic logic pattern_pick(input logic [MODE_W-1:0] mode,
                                         input logic [1:0]        row_lo,
                                         input logic [COL_W-1:0]  col);
      logic even;
      logic pick;
      even = ~row_lo[0];
      unique case (mode)
         MODE_ALL:      pick = 1'b1;
         MODE_CHECKER:  pick = (col[0] == row_lo[0]);
         MODE_EVEN_ALT: pick = even && (col[0] == row_lo[1]);
         MODE_QUARTER:  pick = even && (col[1:0] == 2'd0);
         MODE_EIGHTH:   pick = even && (col[1:0] == 2'd0) && (col[2] == row_lo[1]);
         default:       pick = 1'b1;
      endcase
      return pick;
   endfunction

   function automatic logic mode_is_full(input logic [MODE_W-1:0] mode);
      return (mode == MODE_ALL) || (mode > MODE_EIGHTH);
   endfunction

endpackage

// ----- rtl/dbsad_lane.sv -----
// One pixel lane: masked absolute difference of a target and a candidate pixel.
// Depends on dbsad_pkg.
module dbsad_lane (
   input  logic                            clock,
   input  logic                            enable,
   input  logic                            sel,
   input  logic [dbsad_pkg::PIXEL_W-1:0]   target_pixel,
   input  logic [dbsad_pkg::PIXEL_W-1:0]   cand_pixel,
   output logic [dbsad_pkg::PIXEL_W-1:0]   diff
);
   import dbsad_pkg::*;

   logic [PIXEL_W-1:0] diff_ff;
   logic [PIXEL_W-1:0] diff_in;

   always_comb begin
      if (!sel) begin
         diff_in = '0;
      end else if (cand_pixel > target_pixel) begin
         diff_in = cand_pixel - target_pixel;
      end else begin
         diff_in = target_pixel - cand_pixel;
      end
   end

   // hold while the next stage is full and stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

// ----- rtl/dbsad_merge.sv -----
// Merge stage: registered four-level adder tree over the lane differences.
// Depends on dbsad_pkg.
module dbsad_merge (
   input  logic                              clock,
   input  logic                              enable,
   input  dbsad_pkg::lane_bus_type           diffs,
   output logic [dbsad_pkg::ROW_SUM_W-1:0]   row_sum
);
   import dbsad_pkg::*;

   logic [8:0]           lvl1 [8];
   logic [9:0]           lvl2 [4];
   logic [10:0]          lvl3 [2];
   logic [ROW_SUM_W-1:0] sum_in;
   logic [ROW_SUM_W-1:0] sum_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = {1'b0, diffs[2*i]} + {1'b0, diffs[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      end
      sum_in = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

   assign row_sum = sum_ff;

endmodule

// ----- rtl/decimated_block_sad_early_exit.sv -----
// Top level of the decimated block SAD with early exit.
// Depends on dbsad_pkg, dbsad_lane and dbsad_merge.
//
// Each req_ transfer carries one row of a target and a candidate block
// (BLOCK_SIZE 8-bit pixels each) plus the best SAD so far, sampled on row 0
// of each block only. Rows are counted internally; row BLOCK_SIZE-1 closes it.
// A block yields at most one rsp_ transfer: rejected=1 and sad=0 as soon as
// sum + exit_bias reaches the best so far (after any row in full mode, only
// after the last row otherwise), else rejected=0 with the sampled SAD on the
// last row. Rows after a rejection give nothing.
// Throughput: one row per cycle while rsp_stall stays low. Three stages:
// lanes (absolute differences), merge (adder tree) and accumulate, whose
// running-sum add and compare are combinational and set that rate. A row's
// result passes the lane, merge and output registers in turn.
// Stall: a stage advances when it is empty or its successor advances, so
// bubbles are squeezed out; while a result waits in the output register, up
// to two more rows enter before req_stall rises.
// Reset: synchronous, active high; clears row count, block state, valids
// and both registers (pattern_mode and exit_bias) to zero. Mode writes hit
// the next row, bias writes reach rows not yet summed; write only while idle.
module decimated_block_sad_early_exit #(
   parameter int BLOCK_SIZE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dbsad_pkg::WORD_W-1:0]      req_target_pixels_low,
   input  logic [dbsad_pkg::WORD_W-1:0]      req_target_pixels_high,
   input  logic [dbsad_pkg::WORD_W-1:0]      req_cand_pixels_low,
   input  logic [dbsad_pkg::WORD_W-1:0]      req_cand_pixels_high,
   input  logic [dbsad_pkg::BEST_W-1:0]      req_best_so_far,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_rejected,
   output logic [dbsad_pkg::SAD_W-1:0]       rsp_sad,
   input  logic                              csr_write_enable,
   input  logic [dbsad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dbsad_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import dbsad_pkg::*;

   localparam int ROW_W = $clog2(BLOCK_SIZE);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BLOCK_SIZE - 1);

   // configuration
   logic [MODE_W-1:0] pattern_mode_ff, pattern_mode_in;
   logic [BIAS_W-1:0] exit_bias_ff, exit_bias_in;

   // input side
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [BLOCK_SIZE-1:0] lane_sel;
   row_ctl_type           req_ctl;
   logic                  req_fire;

   // lane and merge stages
   logic          a_valid_ff, a_valid_in;
   row_ctl_type   a_ctl_ff;
   lane_bus_type  a_diffs;
   logic          b_valid_ff, b_valid_in;
   row_ctl_type   b_ctl_ff;
   logic [ROW_SUM_W-1:0] b_row_sum;
   logic          en_a, en_b, en_out;

   // accumulate stage
   logic [SUM_W-1:0]  run_sum_ff, run_sum_in;
   logic [BEST_W-1:0] best_ff, best_in;
   logic              done_ff, done_in;
   logic [SUM_W-1:0]  base_sum, new_sum;
   logic [BEST_W-1:0] cur_best;
   logic              cur_done, check, hit, emit, emit_reject;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_rejected_ff, rsp_rejected_in;
   logic [SAD_W-1:0]  rsp_sad_ff, rsp_sad_in;

   // ---------------- stage enables ----------------
   // advance the output register when empty or taken; earlier stages move
   // when empty or when their successor moves
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_b      = !b_valid_ff || en_out;
   assign en_a      = !a_valid_ff || en_b;
   assign req_stall = !en_a;
   assign req_fire  = req_valid && en_a;

   // ---------------- configuration ----------------
   always_comb begin
      pattern_mode_in = pattern_mode_ff;
      exit_bias_in    = exit_bias_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_MODE: pattern_mode_in = csr_write_data[MODE_W-1:0];
            CSR_EXIT_BIAS:    exit_bias_in    = csr_write_data[BIAS_W-1:0];
         endcase
      end
   end

   // ---------------- row count and lane mask ----------------
   always_comb begin
      row_in = row_ff;
      if (req_fire) begin
         row_in = (row_ff == LAST_ROW) ? '0 : row_ff + ROW_W'(1);
      end
      for (int c = 0; c < BLOCK_SIZE; c++) begin
         lane_sel[c] = pattern_pick(pattern_mode_ff, row_ff[1:0], COL_W'(c));
      end
      req_ctl.first = (row_ff == '0);
      req_ctl.last  = (row_ff == LAST_ROW);
      req_ctl.full  = mode_is_full(pattern_mode_ff);
      req_ctl.best  = req_best_so_far;
   end

   // ---------------- lane stage ----------------
   for (genvar c = 0; c < MAX_LANES; c++) begin : g_lane
      if (c < BLOCK_SIZE) begin : g_used
         logic [PIXEL_W-1:0] tpix, cpix;
         if (c < WORD_PIX) begin : g_low
            assign tpix = req_target_pixels_low[c*PIXEL_W +: PIXEL_W];
            assign cpix = req_cand_pixels_low[c*PIXEL_W +: PIXEL_W];
         end else begin : g_high
            assign tpix = req_target_pixels_high[(c-WORD_PIX)*PIXEL_W +: PIXEL_W];
            assign cpix = req_cand_pixels_high[(c-WORD_PIX)*PIXEL_W +: PIXEL_W];
         end
         dbsad_lane u_lane (
            .clock        (clock),
            .enable       (en_a),
            .sel          (lane_sel[c]),
            .target_pixel (tpix),
            .cand_pixel   (cpix),
            .diff         (a_diffs[c])
         );
      end else begin : g_pad
         assign a_diffs[c] = '0;
      end
   end

   assign a_valid_in = en_a ? req_valid : a_valid_ff;

   // ---------------- merge stage ----------------
   dbsad_merge u_merge (
      .clock   (clock),
      .enable  (en_b),
      .diffs   (a_diffs),
      .row_sum (b_row_sum)
   );

   assign b_valid_in = en_b ? a_valid_ff : b_valid_ff;

   // ---------------- accumulate stage ----------------
   always_comb begin
      // row 0 restarts the block: clear sum and flag, latch the best
      base_sum = b_ctl_ff.first ? '0 : run_sum_ff;
      cur_done = b_ctl_ff.first ? 1'b0 : done_ff;
      cur_best = b_ctl_ff.first ? b_ctl_ff.best : best_ff;
      new_sum  = base_sum + SUM_W'(b_row_sum);
      check    = b_ctl_ff.full || b_ctl_ff.last;
      hit      = ((SUM_W+1)'(new_sum) + (SUM_W+1)'(exit_bias_ff))
                 >= (SUM_W+1)'(cur_best);
      emit_reject = !cur_done && check && hit;
      emit        = emit_reject || (!cur_done && b_ctl_ff.last);

      run_sum_in      = run_sum_ff;
      best_in         = best_ff;
      done_in         = done_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_sad_in      = rsp_sad_ff;
      if (en_out) begin
         rsp_valid_in = b_valid_ff && emit;
         if (b_valid_ff) begin
            run_sum_in      = cur_done ? base_sum : new_sum;
            best_in         = cur_best;
            done_in         = cur_done || emit_reject;
            rsp_rejected_in = emit_reject;
            rsp_sad_in      = emit_reject ? '0 : new_sum[SAD_W-1:0];
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff <= '0;
         exit_bias_ff    <= '0;
         row_ff          <= '0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         run_sum_ff      <= '0;
         best_ff         <= '0;
         done_ff         <= 1'b0;
      end else begin
         pattern_mode_ff <= pattern_mode_in;
         exit_bias_ff    <= exit_bias_in;
         row_ff          <= row_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         run_sum_ff      <= run_sum_in;
         best_ff         <= best_in;
         done_ff         <= done_in;
      end
   end

   // payload: hold unless the stage advances
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ctl_ff <= req_ctl;
      end
      if (en_b) begin
         b_ctl_ff <= a_ctl_ff;
      end
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_sad_ff      <= rsp_sad_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rejected = rsp_rejected_ff;
   assign rsp_sad      = rsp_sad_ff;

`ifndef SYNTHESIS
   // a rejection result always reports a zero SAD
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rejected_ff |-> rsp_sad_ff == '0)
      else $error("rejected result with nonzero sad");

   // a rejection marks the block done for the rows that follow
   a_reject_done: assert property (@(posedge clock) disable iff (reset)
      en_out && b_valid_ff && emit_reject |=> done_ff)
      else $error("block not marked done after rejection");

   // a held result keeps its contents until taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_sad_ff)
                                   && $stable(rsp_rejected_ff))
      else $error("stalled result changed");

   // reset empties the whole pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !a_valid_ff && !b_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- test/tb_decimated_block_sad_early_exit.sv -----
// Testbench for decimated_block_sad_early_exit: drives pixel rows, predicts each block's result
// and checks every rsp_ transfer against it. Depends on dbsad_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_decimated_block_sad_early_exit;
   import dbsad_pkg::*;

   localparam int BLOCK        = 16;
   localparam int RANDOM_ITEMS = 400;
   localparam int IDLE_WAIT    = 8;     // pipeline is three stages deep; leave margin
   localparam int WATCHDOG     = 2000;  // cycles without any transfer

   typedef struct packed {
      logic [WORD_W-1:0] target_lo;
      logic [WORD_W-1:0] target_hi;
      logic [WORD_W-1:0] cand_lo;
      logic [WORD_W-1:0] cand_hi;
      logic [BEST_W-1:0] best;
   } pixel_row_type;

   typedef struct packed {
      logic             rejected;
      logic [SAD_W-1:0] sad;
   } block_result_type;

   typedef enum int {STYLE_RANDOM, STYLE_NEAR, STYLE_SAME, STYLE_EXTREME} pixel_style_type;
   typedef enum int {BEST_RANDOM, BEST_EDGE, BEST_ZERO, BEST_MAX} best_kind_type;

   // DUT inputs, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic [WORD_W-1:0]     req_target_pixels_low = '0;
   logic [WORD_W-1:0]     req_target_pixels_high = '0;
   logic [WORD_W-1:0]     req_cand_pixels_low = '0;
   logic [WORD_W-1:0]     req_cand_pixels_high = '0;
   logic [BEST_W-1:0]     req_best_so_far = '0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // DUT outputs
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_rejected;
   logic [SAD_W-1:0]      rsp_sad;

   // Rows waiting to be driven and results the block still owes us
   pixel_row_type    pending_rows[$];
   block_result_type sad_expected[$];

   // Predictor copy of the block state and its two registers
   logic [MODE_W-1:0] cfg_mode = MODE_ALL;
   logic [BIAS_W-1:0] cfg_bias = '0;
   logic [3:0]        pred_row = '0;
   logic [SUM_W-1:0]  pred_sum = '0;
   logic [BEST_W-1:0] pred_best = '0;
   logic              pred_done = 1'b0;

   int  gen_row = 0;        // row position of the next row to be queued
   int  items_pushed = 0;
   int  fail_count = 0;
   bit  quiet_tail = 1'b0;  // set near the end: no more idling on either side
   int  gap_left = 0;
   bit  gap_cool = 1'b0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   always #2 clock = ~clock;

   decimated_block_sad_early_exit #(
      .BLOCK_SIZE(BLOCK)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_target_pixels_low (req_target_pixels_low),
      .req_target_pixels_high(req_target_pixels_high),
      .req_cand_pixels_low   (req_cand_pixels_low),
      .req_cand_pixels_high  (req_cand_pixels_high),
      .req_best_so_far       (req_best_so_far),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rejected          (rsp_rejected),
      .rsp_sad               (rsp_sad),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // Unknown pattern codes fall back to full sampling.
   function automatic logic [MODE_W-1:0] active_mode(input logic [MODE_W-1:0] mode);
      return (mode > MODE_EIGHTH) ? MODE_ALL : mode;
   endfunction

   // Sum of absolute differences over the columns the pattern keeps on this row.
   function automatic logic [ROW_SUM_W-1:0] row_abs_sum(input pixel_row_type r,
                                                        input logic [3:0] row,
                                                        input logic [MODE_W-1:0] mode);
      logic [2*WORD_W-1:0]  tw;
      logic [2*WORD_W-1:0]  cw;
      logic [PIXEL_W-1:0]   t;
      logic [PIXEL_W-1:0]   c;
      logic [ROW_SUM_W-1:0] acc;
      logic                 take;
      tw  = {r.target_hi, r.target_lo};
      cw  = {r.cand_hi, r.cand_lo};
      acc = '0;
      for (int k = 0; k < BLOCK; k++) begin
         case (mode)
            MODE_CHECKER:  take = (k[0] == row[0]);
            MODE_EVEN_ALT: take = !row[0] && (k[0] == row[1]);
            MODE_QUARTER:  take = !row[0] && (k[1:0] == 2'd0);
            MODE_EIGHTH:   take = !row[0] && (k[2:0] == {row[1], 2'b00});
            default:       take = 1'b1;
         endcase
         t = tw[8*k +: 8];
         c = cw[8*k +: 8];
         if (take) begin
            acc = acc + ((c > t) ? (c - t) : (t - c));
         end
      end
      return acc;
   endfunction

   // Advance the predicted block state by one accepted row; queue a result if one is due.
   task automatic predict_row_sad(input pixel_row_type r);
      logic [MODE_W-1:0] m;
      logic              last;
      logic [SUM_W:0]    biased;
      m    = active_mode(cfg_mode);
      last = (pred_row == BLOCK - 1);
      if (pred_row == 0) begin
         pred_sum  = '0;
         pred_done = 1'b0;
         pred_best = r.best;
      end
      if (!pred_done) begin
         pred_sum = pred_sum + row_abs_sum(r, pred_row, m);
         biased   = {1'b0, pred_sum} + cfg_bias;
         if (m == MODE_ALL || last) begin
            if (biased >= pred_best) begin
               sad_expected.push_back('{rejected: 1'b1, sad: '0});
               pred_done = 1'b1;
            end else if (last) begin
               sad_expected.push_back('{rejected: 1'b0, sad: pred_sum[SAD_W-1:0]});
            end
         end
      end
      pred_row = last ? 4'd0 : pred_row + 4'd1;
   endtask

   function automatic pixel_row_type make_row(input pixel_style_type style);
      pixel_row_type       r;
      logic [2*WORD_W-1:0] tw;
      logic [2*WORD_W-1:0] cw;
      int                  v;
      tw = {$urandom, $urandom, $urandom, $urandom};
      cw = {$urandom, $urandom, $urandom, $urandom};
      case (style)
         STYLE_RANDOM: ;
         STYLE_NEAR: begin
            // nudge each candidate pixel a few levels off the target, clamped
            for (int k = 0; k < BLOCK; k++) begin
               v = int'(tw[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               cw[8*k +: 8] = v[7:0];
            end
         end
         STYLE_SAME: cw = tw;
         default: begin
            for (int k = 0; k < BLOCK; k++) begin
               tw[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            cw = ~tw;
         end
      endcase
      r.target_lo = tw[WORD_W-1:0];
      r.target_hi = tw[2*WORD_W-1:WORD_W];
      r.cand_lo   = cw[WORD_W-1:0];
      r.cand_hi   = cw[2*WORD_W-1:WORD_W];
      r.best      = BEST_W'($urandom_range(0, 131071));
      return r;
   endfunction

   task automatic push_row(input pixel_row_type r);
      pending_rows.push_back(r);
      gen_row = (gen_row == BLOCK - 1) ? 0 : gen_row + 1;
      items_pushed++;
   endtask

   // Queue the rest of the current block. On row 0 pick a best so far; the edge kind
   // puts it within 4 of the final sum plus bias so the compare lands on either side.
   task automatic queue_block(input pixel_style_type style, input best_kind_type kind,
                              input bit cut);
      pixel_row_type rows[BLOCK];
      int            first;
      int            count;
      int            level;
      int            total;
      first = gen_row;
      count = BLOCK - first;
      total = 0;
      for (int i = 0; i < count; i++) begin
         rows[i] = make_row(style);
         total += int'(row_abs_sum(rows[i], 4'(first + i), active_mode(cfg_mode)));
      end
      if (first == 0) begin
         case (kind)
            BEST_EDGE: begin
               level = total + int'(cfg_bias) + int'($urandom_range(0, 8)) - 4;
               if (level < 0) level = 0;
               if (level > 131071) level = 131071;
               rows[0].best = level[BEST_W-1:0];
            end
            BEST_ZERO: rows[0].best = '0;
            BEST_MAX:  rows[0].best = '1;
            default:   ;
         endcase
      end
      // a cut block ends the phase mid-block, so the next setting lands inside it
      if (cut && count > 1) count = $urandom_range(1, count - 1);
      for (int i = 0; i < count; i++) begin
         push_row(rows[i]);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until every row is in and every result out, then let rows without a result flush.
   task automatic drain_block(input int cycles);
      while (pending_rows.size() != 0 || sad_expected.size() != 0) @(negedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   // Driver: predict on each transfer, then present the next row or idle for a burst.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left   = 0;
         gap_cool   = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_row_sad(pending_rows[0]);
            void'(pending_rows.pop_front());
         end
         // hold the payload while stalled; otherwise choose what goes out next
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left--;
               gap_cool = 1'b1;
            end else if (!quiet_tail && !gap_cool && $urandom_range(0, 7) == 0) begin
               req_valid <= 1'b0;
               gap_left   = $urandom_range(0, 15);
            end else if (pending_rows.size() != 0) begin
               gap_cool = 1'b0;
               req_valid              <= 1'b1;
               req_target_pixels_low  <= pending_rows[0].target_lo;
               req_target_pixels_high <= pending_rows[0].target_hi;
               req_cand_pixels_low    <= pending_rows[0].cand_lo;
               req_cand_pixels_high   <= pending_rows[0].cand_hi;
               req_best_so_far        <= pending_rows[0].best;
            end else begin
               gap_cool = 1'b0;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer, and stall in random bursts.
   always @(posedge clock) begin
      block_result_type exp_res;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sad_expected.size() == 0) begin
               $error("result transfer with nothing expected: rejected %0d, sad %0d",
                      rsp_rejected, rsp_sad);
               fail_count++;
            end else begin
               exp_res = sad_expected.pop_front();
               if (rsp_rejected !== exp_res.rejected) begin
                  $error("rejected: expected %0d, actual %0d", exp_res.rejected, rsp_rejected);
                  fail_count++;
               end
               if (rsp_sad !== exp_res.sad) begin
                  $error("sad: expected %0d, actual %0d", exp_res.sad, rsp_sad);
                  fail_count++;
               end
            end
         end
         // always drop stall between bursts
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!quiet_tail && !rsp_stall && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            hold_left  = $urandom_range(0, 15);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      pixel_row_type r;
      int            phase;
      logic [2:0]    mode_pick;
      logic [15:0]   bias_pick;
      int            blocks;
      bit            cut;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset settings (full mode, no bias).
      // Worst-case block: target black, candidate white, best at max -> sad reaches 65280.
      for (int i = 0; i < BLOCK; i++) begin
         r = '{target_lo: '0, target_hi: '0, cand_lo: '1, cand_hi: '1,
               best: (i == 0) ? '1 : BEST_W'($urandom)};
         push_row(r);
      end
      // Best of zero rejects on row 0 even with identical rows; following rows give nothing
      // and their best field must be ignored.
      for (int i = 0; i < 9; i++) begin
         r = make_row(STYLE_SAME);
         if (i == 0) r.best = '0;
         push_row(r);
      end

      // Random phases. The block is left mid-block here, so the first write lands inside it.
      phase = 0;
      while (items_pushed < RANDOM_ITEMS + 25) begin
         drain_block(IDLE_WAIT);
         // walk every code and both bias extremes first, then pick at random
         mode_pick = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
         case ((phase < 8) ? phase % 4 : $urandom_range(0, 3))
            0:       bias_pick = '0;
            1:       bias_pick = '1;
            2:       bias_pick = 16'($urandom_range(0, 64));
            default: bias_pick = 16'($urandom);
         endcase
         write_csr(CSR_PATTERN_MODE, CSR_DATA_W'(mode_pick));
         write_csr(CSR_EXIT_BIAS, bias_pick);
         cfg_mode = mode_pick;
         cfg_bias = bias_pick;
         @(negedge clock);

         if (items_pushed >= (RANDOM_ITEMS * 7) / 8) quiet_tail = 1'b1;
         blocks = $urandom_range(1, 3);
         for (int b = 0; b < blocks; b++) begin
            cut = (b == blocks - 1) && ($urandom_range(0, 4) == 0);
            queue_block(pixel_style_type'($urandom_range(0, 3)),
                        ($urandom_range(0, 2) == 0) ? best_kind_type'($urandom_range(0, 3))
                                                    : BEST_EDGE,
                        cut);
         end
         phase++;
      end

      drain_block(IDLE_WAIT);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dbsad_pkg.sv
rtl/dbsad_lane.sv
rtl/dbsad_merge.sv
rtl/decimated_block_sad_early_exit.sv
test/tb_decimated_block_sad_early_exit.sv
